// ----- src/mm3_pkg.sv -----
package mm3_pkg;

    localparam logic [31:0] MM_C1      = 32'hcc9e2d51;
    localparam logic [31:0] MM_C2      = 32'h1b873593;
    localparam logic [31:0] MM_N       = 32'he6546b64;
    localparam logic [31:0] MM_F1      = 32'h85ebca6b;
    localparam logic [31:0] MM_F2      = 32'hc2b2ae35;
    localparam logic [31:0] SEED_RESET = 32'hb6d99cf8;

    localparam int unsigned ROT_BLK  = 15;
    localparam int unsigned ROT_HASH = 13;

    typedef enum logic [1:0] {
        MUL_C1,
        MUL_C2,
        MUL_F1,
        MUL_F2
    } t_mul_op;

    typedef struct packed {
        logic    en;
        t_mul_op op;
    } t_mul_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BLK_C1,
        S_BLK_C2,
        S_BLK_FOLD,
        S_TAIL,
        S_TL_C2,
        S_TL_XOR,
        S_FIN_F1,
        S_FIN_F2,
        S_FIN_OUT
    } t_state;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned r);
        logic [63:0] dbl;
        dbl = {x, x} << r;
        return dbl[63:32];
    endfunction

endpackage

// ----- src/mm3_mul.sv -----
module mm3_mul (
    input  logic              i_clk,
    input  mm3_pkg::t_mul_req i_req,
    input  logic [31:0]       i_operand,
    output logic [31:0]       o_product
);
    import mm3_pkg::*;

    logic [31:0] coef;
    logic [63:0] full;
    logic [31:0] r_product;

    always_comb begin
        case (i_req.op)
            MUL_C1:  coef = MM_C1;
            MUL_C2:  coef = MM_C2;
            MUL_F1:  coef = MM_F1;
            MUL_F2:  coef = MM_F2;
            default: coef = MM_C1;
        endcase
    end

    assign full = i_operand * coef;

    // product holds when idle so a waiting consumer can still read it
    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_product <= full[31:0];
        end
    end

    assign o_product = r_product;

endmodule

// ----- src/murmur3_32_key_hash_core.sv -----
// A byte that does not complete a block and is not last leaves the block in S_IDLE; a
// byte that completes a 4-byte block runs S_BLK_C1, S_BLK_C2 and S_BLK_FOLD (two multiplies and a fold).
// The last item's result is registered after the tail steps (S_TAIL, and with pending bytes
// S_TL_C2 and S_TL_XOR) and the finalizer steps (S_FIN_F1, S_FIN_F2, S_FIN_OUT), set by the one
// shared 32x32 multiplier used in turn for block, tail and finalizer steps; a stalled older
// result delays it further. No new item is taken while a key step runs.
// Reset (synchronous, i_rst_n low): idle, key state cleared, seed 0xb6d99cf8.
module murmur3_32_key_hash_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_key_byte,
    input  logic        i_has_byte,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_hash_value,
    output logic [31:0] o_key_length,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);
    import mm3_pkg::*;

    t_state      r_state, n_state;
    logic [31:0] r_seed;
    logic [31:0] r_hash, n_hash;
    logic [31:0] r_acc, n_acc;
    logic [23:0] r_pending, n_pending;
    logic [1:0]  r_phase, n_phase;
    logic [31:0] r_total, n_total;
    logic        r_key_open, n_key_open;
    logic        r_fin, n_fin;
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_out_hash, n_out_hash;
    logic [31:0] r_out_len, n_out_len;

    t_mul_req    mul_req;
    logic [31:0] mul_in;
    logic [31:0] mul_prod;
    logic [31:0] mix;
    logic        in_acc;
    logic        out_free;

    mm3_mul u_mul (
        .i_clk     (i_clk),
        .i_req     (mul_req),
        .i_operand (mul_in),
        .o_product (mul_prod)
    );

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_hash      = r_hash;
        n_acc       = r_acc;
        n_pending   = r_pending;
        n_phase     = r_phase;
        n_total     = r_total;
        n_key_open  = r_key_open;
        n_fin       = r_fin;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_hash  = r_out_hash;
        n_out_len   = r_out_len;
        mul_req.en  = 1'b0;
        mul_req.op  = MUL_C1;
        mul_in      = r_acc;
        mix         = rotl32(r_hash ^ mul_prod, ROT_HASH);

        case (r_state)
            S_IDLE: begin
                // an item with neither byte nor last is taken and dropped
                if (in_acc && (i_has_byte || i_last)) begin
                    if (!r_key_open) begin
                        n_hash     = r_seed;
                        n_key_open = 1'b1;
                    end
                    n_fin = i_last;
                    if (i_has_byte) begin
                        n_total = r_total + 32'd1;
                        if (r_phase == 2'd3) begin
                            n_acc     = {i_key_byte, r_pending};
                            n_pending = '0;
                            n_phase   = '0;
                            n_state   = S_BLK_C1;
                        end else begin
                            n_pending = r_pending | (24'(i_key_byte) << {r_phase, 3'b000});
                            n_phase   = r_phase + 2'd1;
                            if (i_last) begin
                                n_state = S_TAIL;
                            end
                        end
                    end else begin
                        n_state = S_TAIL;
                    end
                end
            end
            S_BLK_C1: begin
                mul_req.en = 1'b1;
                mul_req.op = MUL_C1;
                mul_in     = r_acc;
                n_state    = S_BLK_C2;
            end
            S_BLK_C2: begin
                mul_req.en = 1'b1;
                mul_req.op = MUL_C2;
                mul_in     = rotl32(mul_prod, ROT_BLK);
                n_state    = S_BLK_FOLD;
            end
            S_BLK_FOLD: begin
                // times 5 as shift-add
                n_hash  = mix + {mix[29:0], 2'b00} + MM_N;
                n_state = r_fin ? S_TAIL : S_IDLE;
            end
            S_TAIL: begin
                if (r_phase != 2'd0) begin
                    mul_req.en = 1'b1;
                    mul_req.op = MUL_C1;
                    mul_in     = {8'h00, r_pending};
                    n_state    = S_TL_C2;
                end else begin
                    n_acc   = r_hash ^ r_total;
                    n_state = S_FIN_F1;
                end
            end
            S_TL_C2: begin
                mul_req.en = 1'b1;
                mul_req.op = MUL_C2;
                mul_in     = rotl32(mul_prod, ROT_BLK);
                n_state    = S_TL_XOR;
            end
            S_TL_XOR: begin
                n_acc   = r_hash ^ mul_prod ^ r_total;
                n_state = S_FIN_F1;
            end
            S_FIN_F1: begin
                mul_req.en = 1'b1;
                mul_req.op = MUL_F1;
                mul_in     = r_acc ^ (r_acc >> 16);
                n_state    = S_FIN_F2;
            end
            S_FIN_F2: begin
                mul_req.en = 1'b1;
                mul_req.op = MUL_F2;
                mul_in     = mul_prod ^ (mul_prod >> 13);
                n_state    = S_FIN_OUT;
            end
            S_FIN_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_hash  = mul_prod ^ (mul_prod >> 16);
                    n_out_len   = r_total;
                    n_pending   = '0;
                    n_phase     = '0;
                    n_total     = '0;
                    n_key_open  = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seed      <= SEED_RESET;
            r_pending   <= '0;
            r_phase     <= '0;
            r_total     <= '0;
            r_key_open  <= 1'b0;
            r_fin       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pending   <= n_pending;
            r_phase     <= n_phase;
            r_total     <= n_total;
            r_key_open  <= n_key_open;
            r_fin       <= n_fin;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_seed <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hash     <= n_hash;
        r_acc      <= n_acc;
        r_out_hash <= n_out_hash;
        r_out_len  <= n_out_len;
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_hash_value = r_out_hash;
    assign o_key_length = r_out_len;
    assign o_cfg_ready  = 1'b1;

endmodule

// ----- src/mm3_chk.sv -----
module mm3_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        i_last,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_hash_value,
    input logic [31:0] o_key_length
);

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    // a result never shows up the cycle right after an item is taken
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !$rose(o_out_valid))
        else $error("result appeared one cycle after an item");

    // a last item always starts the finish, during which the block stalls input
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_last) |=> o_in_stall)
        else $error("block took a new item right after a last item");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_hash_value) && $stable(o_key_length)))
        else $error("stalled result changed");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind murmur3_32_key_hash_core mm3_chk u_mm3_chk (.*);
